// File: design/fir_pkg.sv
// Shared constants and types for the FIR filter unit.
// No dependencies; every other design file but fir_ram refers to this package.
package fir_pkg;

	localparam int DEF_MAX_TAPS    = 64;
	localparam int SAMPLE_BITS     = 16;
	localparam int COEF_BITS       = 16;
	localparam int COEF_INDEX_BITS = 6;
	localparam int TAP_COUNT_BITS  = 7;
	localparam int ROUND_SHIFT     = 15;
	localparam int APB_ADDR_BITS   = 3;
	localparam int APB_DATA_BITS   = 32;

	localparam logic [0:0] REG_TAP_COUNT = 1'b0;
	localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = TAP_COUNT_BITS'(1);

	typedef enum logic [0:0] {
		KIND_SAMPLE = 1'b0,
		KIND_COEF   = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                              kind;
		logic signed [SAMPLE_BITS-1:0]      sample;
		logic        [COEF_INDEX_BITS-1:0]  coef_index;
		logic signed [COEF_BITS-1:0]        coef_value;
		logic                               coef_ok;
	} op_t;

endpackage

// File: design/fir_in_if.sv
// Request channel of the FIR filter unit: samples and coefficient writes.
// Depends on fir_pkg for field widths.
interface fir_in_if;
	logic                                        valid;
	logic                                        ready;
	logic                                        kind;
	logic signed [fir_pkg::SAMPLE_BITS-1:0]      sample_in;
	logic        [fir_pkg::COEF_INDEX_BITS-1:0]  coef_index;
	logic signed [fir_pkg::COEF_BITS-1:0]        coef_value;

	modport source(output valid, kind, sample_in, coef_index, coef_value, input ready);
	modport sink(input valid, kind, sample_in, coef_index, coef_value, output ready);
endinterface

// File: design/fir_out_if.sv
// Result channel of the FIR filter unit: filtered samples.
// Depends on fir_pkg for field widths.
interface fir_out_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [fir_pkg::SAMPLE_BITS-1:0]  sample_out;

	modport source(output valid, sample_out, input ready);
	modport sink(input valid, sample_out, output ready);
endinterface

// File: design/fir_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fir_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/fir_front.sv
// Front end: accepts requests, classifies them and queues them for the MAC engine.
// Depends on fir_pkg and fir_in_if.
module fir_front #(
	parameter int MAX_TAPS = fir_pkg::DEF_MAX_TAPS
) (
	input  logic           clk,
	input  logic           arst_n,
	fir_in_if.sink         stream,
	output logic           op_valid,
	input  logic           op_ready,
	output fir_pkg::op_t   op
);
	localparam int QD = 2;
	localparam int QW = $clog2(QD);

	fir_pkg::op_t    q_mem_q [QD];
	logic [QW-1:0]   wr_q;
	logic [QW-1:0]   rd_q;
	logic [QW:0]     cnt_q;
	fir_pkg::op_t    in_op;
	logic            push;
	logic            pop;

	always_comb begin
		in_op.kind       = fir_pkg::kind_t'(stream.kind);
		in_op.sample     = stream.sample_in;
		in_op.coef_index = stream.coef_index;
		in_op.coef_value = stream.coef_value;
		in_op.coef_ok    = (32'(stream.coef_index) < MAX_TAPS);
	end

	assign stream.ready = (cnt_q != (QW+1)'(QD));
	assign push         = stream.valid && stream.ready;
	assign op_valid     = (cnt_q != '0);
	assign pop          = op_valid && op_ready;
	assign op           = q_mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_q] <= in_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QW+1)'(1);
			end
		end
	end
endmodule

// File: design/fir_back.sv
// Back end: one shared multiply-accumulate steps through the taps of each sample.
// Depends on fir_pkg, fir_out_if and fir_ram (history and coefficient stores).
module fir_back #(
	parameter int MAX_TAPS = fir_pkg::DEF_MAX_TAPS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [fir_pkg::TAP_COUNT_BITS-1:0]    tap_count,
	input  logic                                  op_valid,
	output logic                                  op_ready,
	input  fir_pkg::op_t                          op,
	fir_out_if.source                             result
);
	localparam int SB         = fir_pkg::SAMPLE_BITS;
	localparam int CB         = fir_pkg::COEF_BITS;
	localparam int HIST_DEPTH = MAX_TAPS - 1;
	localparam int HAW        = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int CAW        = $clog2(MAX_TAPS);
	localparam int TCW        = $clog2(MAX_TAPS + 1);
	localparam int FW         = $clog2(HIST_DEPTH + 1);
	localparam int PROD_W     = SB + CB;
	localparam int ACC_W      = PROD_W + $clog2(MAX_TAPS);
	localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(2 ** (fir_pkg::ROUND_SHIFT - 1));
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (SB - 1) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t                    state_q;
	logic [TCW-1:0]            taps_q;
	logic [TCW-1:0]            j_q;
	logic [HAW-1:0]            rp_q;
	logic [HAW-1:0]            wp_q;
	logic [FW-1:0]             fill_q;
	logic signed [SB-1:0]      x_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      out_valid_q;
	logic signed [SB-1:0]      out_data_q;

	logic                      valid_s1;
	logic                      first_s1;
	logic                      hv_s1;
	logic                      valid_s2;
	logic signed [PROD_W-1:0]  prod_s2;

	logic                      issue;
	logic                      hv;
	logic [TCW-1:0]            taps_eff;
	logic signed [SB-1:0]      operand;
	logic signed [ACC_W-1:0]   rnd;
	logic signed [ACC_W-1:0]   shr;
	logic signed [SB-1:0]      sat;
	logic                      finish;
	logic                      take;

	logic                      hist_we;
	logic [SB-1:0]             hist_rdata;
	logic                      coef_we;
	logic [CB-1:0]             coef_rdata;

	fir_ram #(.WIDTH(SB), .DEPTH(HIST_DEPTH)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (wp_q),
		.wdata (x_q),
		.raddr (rp_q),
		.rdata (hist_rdata)
	);

	fir_ram #(.WIDTH(CB), .DEPTH(MAX_TAPS)) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (CAW'(op.coef_index)),
		.wdata (op.coef_value),
		.raddr (CAW'(j_q)),
		.rdata (coef_rdata)
	);

	always_comb begin
		if (tap_count == '0) begin
			taps_eff = TCW'(1);
		end else if (32'(tap_count) > MAX_TAPS) begin
			taps_eff = TCW'(MAX_TAPS);
		end else begin
			taps_eff = TCW'(tap_count);
		end
	end

	assign op_ready = (state_q == S_IDLE);
	assign take     = op_valid && op_ready;
	assign coef_we  = take && (op.kind == fir_pkg::KIND_COEF) && op.coef_ok;
	assign issue    = (state_q == S_RUN);
	assign hv       = (32'(rp_q) < 32'(fill_q));
	assign finish   = (state_q == S_FINISH) && (!out_valid_q || result.ready);
	assign hist_we  = finish;

	assign operand = first_s1 ? x_q : (hv_s1 ? $signed(hist_rdata) : '0);

	always_comb begin
		rnd = acc_q + HALF;
		shr = rnd >>> fir_pkg::ROUND_SHIFT;
		if (shr > SAT_HI) begin
			sat = SB'(SAT_HI);
		end else if (shr < SAT_LO) begin
			sat = SB'(SAT_LO);
		end else begin
			sat = shr[SB-1:0];
		end
	end

	assign result.valid      = out_valid_q;
	assign result.sample_out = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (j_q == '0);
		hv_s1    <= hv;
		prod_s2  <= operand * $signed(coef_rdata);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			taps_q      <= '0;
			j_q         <= '0;
			rp_q        <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			x_q         <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (result.ready && !finish) begin
				out_valid_q <= 1'b0;
			end
			if (valid_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
			unique case (state_q)
				S_IDLE: begin
					if (take && op.kind == fir_pkg::KIND_SAMPLE) begin
						x_q     <= op.sample;
						taps_q  <= taps_eff;
						j_q     <= '0;
						rp_q    <= wp_q;
						acc_q   <= '0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					j_q  <= j_q + TCW'(1);
					rp_q <= (rp_q == '0) ? HAW'(HIST_DEPTH - 1) : rp_q - HAW'(1);
					if (j_q == taps_q - TCW'(1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!valid_s1 && !valid_s2) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (finish) begin
						wp_q        <= (wp_q == HAW'(HIST_DEPTH - 1)) ? '0 : wp_q + HAW'(1);
						fill_q      <= (fill_q == FW'(HIST_DEPTH)) ? fill_q : fill_q + FW'(1);
						out_data_q  <= sat;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: design/fir_filter_unit.sv
// Top level of the FIR filter unit: APB register, front end and MAC back end.
// Depends on fir_pkg, fir_in_if, fir_out_if, fir_front and fir_back.
//
//   channel   direction  handshake          payload
//   stream    in         valid/ready        kind, sample_in, coef_index, coef_value
//   result    out        valid/ready        sample_out
//   apb       in         psel/penable       tap_count at byte address 0
//
// A sample holds the single shared multiply-accumulate while it steps over its
// taps via the history and coefficient RAM read ports, then drains, rounds and
// posts the result; the next request is taken after that. Its tap count is
// tap_count, with zero counted as one and values above MAX_TAPS as MAX_TAPS.
// A two-entry queue keeps taking requests while the MAC works or a result waits;
// a waiting result stalls only the MAC. Coefficient writes wait for an idle MAC.
// Reset clears history (by fill count) and the pointer, and sets tap_count to one.
module fir_filter_unit #(
	parameter int MAX_TAPS = fir_pkg::DEF_MAX_TAPS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	fir_in_if.sink                                stream,
	fir_out_if.source                             result,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [fir_pkg::APB_ADDR_BITS-1:0]     paddr,
	input  logic [fir_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic [fir_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                  pready
);
	logic [fir_pkg::TAP_COUNT_BITS-1:0] tap_count_q;
	logic                               op_valid;
	logic                               op_ready;
	fir_pkg::op_t                       op;

	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[2] == fir_pkg::REG_TAP_COUNT) begin
			prdata = fir_pkg::APB_DATA_BITS'(tap_count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= fir_pkg::TAP_COUNT_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == fir_pkg::REG_TAP_COUNT) begin
			tap_count_q <= pwdata[fir_pkg::TAP_COUNT_BITS-1:0];
		end
	end

	fir_front #(.MAX_TAPS(MAX_TAPS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op)
	);

	fir_back #(.MAX_TAPS(MAX_TAPS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tap_count (tap_count_q),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op),
		.result    (result)
	);
endmodule

// File: design/fir_checker.sv
// Port-level checks for the FIR filter unit, bound to its top level.
// Depends on fir_pkg and fir_filter_unit.
module fir_props (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  in_kind,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic [fir_pkg::SAMPLE_BITS-1:0]       out_data,
	input logic                                  psel,
	input logic                                  penable,
	input logic                                  pwrite,
	input logic [fir_pkg::APB_ADDR_BITS-1:0]     paddr,
	input logic [fir_pkg::APB_DATA_BITS-1:0]     pwdata,
	input logic [fir_pkg::APB_DATA_BITS-1:0]     prdata
);
	logic [3:0] pending_q;
	logic       sample_in_acc;
	logic       result_acc;

	assign sample_in_acc = in_valid && in_ready && (in_kind == fir_pkg::KIND_SAMPLE);
	assign result_acc    = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (sample_in_acc && !result_acc) begin
			pending_q <= pending_q + 4'd1;
		end else if (result_acc && !sample_in_acc) begin
			pending_q <= pending_q - 4'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 4'd0)
		else $error("result without an outstanding sample");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'd4)
		else $error("more samples outstanding than the unit can hold");

	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr[2] == fir_pkg::REG_TAP_COUNT
		|=> paddr[2] != fir_pkg::REG_TAP_COUNT
			|| prdata[fir_pkg::TAP_COUNT_BITS-1:0]
				== $past(pwdata[fir_pkg::TAP_COUNT_BITS-1:0]))
		else $error("tap_count readback differs from written value");
endmodule

bind fir_filter_unit fir_props u_fir_props (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (stream.valid),
	.in_ready  (stream.ready),
	.in_kind   (stream.kind),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.sample_out),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);

// File: sim/fir_checker.sv
// Checker for the FIR filter unit: watches the request, result and APB ports,
// predicts each filtered sample and compares it with what the block returns.
// Depends on fir_pkg, fir_in_if and fir_out_if.
module fir_checker
	import fir_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	fir_in_if                        stream,
	fir_out_if                       result,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	input  logic [APB_DATA_BITS-1:0] prdata,
	input  logic                     pready,
	output int                       fail_count,
	output int                       pending
);

	localparam int MAX_TAPS = DEF_MAX_TAPS;
	localparam int HIST_DEPTH = MAX_TAPS - 1;
	localparam logic [APB_ADDR_BITS-1:0] TAP_ADDR = APB_ADDR_BITS'(4 * REG_TAP_COUNT);

	logic signed [SAMPLE_BITS-1:0] hist [HIST_DEPTH];
	logic signed [COEF_BITS-1:0]   coef [MAX_TAPS];
	int                            wr_ptr;
	logic [TAP_COUNT_BITS-1:0]     tap_reg;
	logic signed [SAMPLE_BITS-1:0] filtered_q [$];

	function automatic logic signed [SAMPLE_BITS-1:0] filter_sample(
		input logic signed [SAMPLE_BITS-1:0] x
	);
		int     taps;
		int     slot;
		int     j;
		longint acc;
		longint y;
		longint hi;
		longint lo;
		taps = int'(tap_reg);
		if (taps < 1) begin
			taps = 1;
		end
		if (taps > MAX_TAPS) begin
			taps = MAX_TAPS;
		end
		acc = longint'(x) * longint'(coef[0]);
		for (j = 1; j < taps; j++) begin
			slot = (wr_ptr + HIST_DEPTH - j) % HIST_DEPTH;
			acc += longint'(hist[slot]) * longint'(coef[j]);
		end
		hist[wr_ptr] = x;
		wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
		// round half up, then clamp to the sample range
		y = (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
		hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		lo = -hi - 1;
		if (y > hi) begin
			y = hi;
		end
		if (y < lo) begin
			y = lo;
		end
		return SAMPLE_BITS'(y);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [SAMPLE_BITS-1:0] want;
		if (!arst_n) begin
			foreach (hist[i]) begin
				hist[i] = '0;
			end
			foreach (coef[i]) begin
				coef[i] = '0;
			end
			wr_ptr = 0;
			tap_reg = TAP_COUNT_RESET;
			filtered_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (filtered_q.size() == 0) begin
					$error("sample_out: no result expected, actual %0d", result.sample_out);
					fail_count++;
				end else begin
					want = filtered_q.pop_front();
					if (result.sample_out !== want) begin
						$error("sample_out: expected %0d, actual %0d", want, result.sample_out);
						fail_count++;
					end
				end
			end
			if (stream.valid && stream.ready) begin
				if (stream.kind == KIND_COEF) begin
					if (int'(stream.coef_index) < MAX_TAPS) begin
						coef[stream.coef_index] = stream.coef_value;
					end
				end else begin
					filtered_q.push_back(filter_sample(stream.sample_in));
				end
			end
			if (psel && penable && pready && paddr == TAP_ADDR) begin
				if (pwrite) begin
					tap_reg = pwdata[TAP_COUNT_BITS-1:0];
				end else if (prdata !== APB_DATA_BITS'(tap_reg)) begin
					$error("tap_count: expected %0d, actual %0d", tap_reg, prdata);
					fail_count++;
				end
			end
			pending = filtered_q.size();
		end
	end

endmodule

// File: sim/tb_top.sv
// Testbench top for the FIR filter unit: clock, reset, request and APB stimulus,
// result back-pressure, watchdog and verdict. Depends on fir_pkg, fir_in_if,
// fir_out_if, fir_filter_unit and fir_checker.
module tb_top;
	import fir_pkg::*;

	localparam int MAX_TAPS = DEF_MAX_TAPS;
	localparam int SETTLE_CYCLES = MAX_TAPS + 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS = 115;
	localparam logic [APB_ADDR_BITS-1:0] TAP_ADDR = APB_ADDR_BITS'(4 * REG_TAP_COUNT);

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;
	int                       fail_count;
	int                       pending;
	int                       idle_cycles;
	int                       burst_left;
	int                       requests_sent;
	int                       active_taps;
	bit                       coef_loaded [MAX_TAPS];

	fir_in_if  in_if ();
	fir_out_if out_if ();

	fir_filter_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (in_if),
		.result  (out_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	fir_checker i_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (in_if),
		.result     (out_if),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
			    (psel && penable)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int  mode;
		int  window;
		int  stall_left;
		bit  rdy;
		mode = 0;
		window = 0;
		stall_left = 0;
		out_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (window == 0) begin
				mode = $urandom_range(0, 3);
				window = $urandom_range(50, 400);
			end
			window--;
			if (stall_left > 0) begin
				rdy = 1'b0;
				stall_left--;
			end else begin
				case (mode)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom_range(0, 1));
					2: begin
						rdy = ($urandom_range(0, 9) != 0);
						if (!rdy) begin
							stall_left = $urandom_range(5, 40);
						end
					end
					default: rdy = ($urandom_range(0, 3) == 0);
				endcase
			end
			out_if.ready <= rdy;
		end
	end

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(0, 15))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'sh0000;
			3: return 16'shFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic push(kind_t k, logic signed [SAMPLE_BITS-1:0] smp,
	                    logic [COEF_INDEX_BITS-1:0] idx, logic signed [COEF_BITS-1:0] val);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_if.valid      <= 1'b1;
		in_if.kind       <= k;
		in_if.sample_in  <= smp;
		in_if.coef_index <= idx;
		in_if.coef_value <= val;
		do @(posedge clk); while (!in_if.ready);
		if (k == KIND_COEF) begin
			coef_loaded[idx] = 1'b1;
		end
		requests_sent++;
	endtask

	task automatic load_coef(int idx, logic signed [COEF_BITS-1:0] val);
		push(KIND_COEF, pick_value(), COEF_INDEX_BITS'(idx), val);
	endtask

	// load any tap in use that was never written before the sample goes in
	task automatic feed_sample(logic signed [SAMPLE_BITS-1:0] smp);
		int j;
		for (j = 0; j < active_taps; j++) begin
			if (!coef_loaded[j]) begin
				load_coef(j, pick_value());
			end
		end
		push(KIND_SAMPLE, smp, COEF_INDEX_BITS'($urandom_range(0, 63)), pick_value());
	endtask

	task automatic settle();
		@(negedge clk);
		in_if.valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_taps(logic [APB_DATA_BITS-1:0] v);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TAP_ADDR;
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		active_taps = int'(v[TAP_COUNT_BITS-1:0]);
		if (active_taps < 1) begin
			active_taps = 1;
		end
		if (active_taps > MAX_TAPS) begin
			active_taps = MAX_TAPS;
		end
	endtask

	initial begin
		int tap_plan [10];
		int phase;
		int phase_end;
		tap_plan = '{64, 3, 127, 1, 8, 0, 2, 33, 100, 5};
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.kind = KIND_SAMPLE;
		in_if.sample_in = '0;
		in_if.coef_index = '0;
		in_if.coef_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_cycles = 0;
		burst_left = 0;
		requests_sent = 0;
		active_taps = 1;
		foreach (coef_loaded[i]) begin
			coef_loaded[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// run on the reset tap count first
		load_coef(0, 16'sh7FFF);
		feed_sample(16'sh7FFF);
		feed_sample(16'sh8000);
		feed_sample(16'sh0000);
		load_coef(0, 16'sh8000);
		feed_sample(16'sh8000);
		feed_sample(16'sh7FFF);
		feed_sample(16'sh0001);
		load_coef(0, 16'sh4000);
		feed_sample(16'sh0001);
		feed_sample(16'shFFFF);
		feed_sample(16'sh0003);
		feed_sample(-16'sd3);
		load_coef(63, 16'sh8000);
		load_coef(1, 16'sh7FFF);
		load_coef(0, 16'sh7FFF);
		set_taps(2);
		feed_sample(16'sh8000);
		feed_sample(16'sh8000);
		feed_sample(16'sh7FFF);
		feed_sample(16'sh7FFF);
		set_taps(0);
		feed_sample(16'sh1234);

		for (phase = 0; phase < 10; phase++) begin
			set_taps(phase == 8 ? $urandom_range(2, 63) : tap_plan[phase]);
			phase_end = requests_sent + PHASE_ITEMS;
			while (requests_sent < phase_end) begin
				if ($urandom_range(0, 149) == 0) begin
					settle();
				end
				if ($urandom_range(0, 99) < 22) begin
					load_coef($urandom_range(0, MAX_TAPS - 1), pick_value());
				end else begin
					feed_sample(pick_value());
				end
			end
		end

		settle();
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: fir_filter_unit.f
design/fir_pkg.sv
design/fir_in_if.sv
design/fir_out_if.sv
design/fir_ram.sv
design/fir_front.sv
design/fir_back.sv
design/fir_filter_unit.sv
design/fir_checker.sv
sim/fir_checker.sv
sim/tb_top.sv
